// ===== rtl/wvcd_pkg.sv =====
// Package for the windowed variance change detector.
// Holds window sizing, reset constants, payload structs and the sequencer state type.
// No dependencies.
package wvcd_pkg;

  // The window length must be a power of two: N and N*N*4096 scale by shifts.
  localparam int WIN_LEN   = 16;
  localparam int WIN_AW    = $clog2(WIN_LEN);
  localparam int SMP_W     = 16;
  localparam int SUM_W     = SMP_W + WIN_AW;
  localparam int SQ_W      = 2 * SMP_W + WIN_AW;
  localparam int NUM_W     = 2 * SMP_W + 2 * WIN_AW;
  localparam int DEN_SHIFT = 2 * WIN_AW + 12;
  localparam int VAR_W     = NUM_W - DEN_SHIFT;
  localparam int CONF_W    = 13;

  localparam logic [SMP_W-1:0]  FRIC_FILL      = 16'd2458;
  localparam logic [SMP_W-1:0]  SLIP_FILL      = 16'd0;
  localparam logic [SMP_W-1:0]  FRIC_THR_RESET = 16'd410;
  localparam logic [SMP_W-1:0]  SLIP_THR_RESET = 16'd205;
  localparam logic [CONF_W-1:0] CONF_MAX       = 13'd4096;

  localparam int               CFG_AW       = 3;
  localparam logic             REG_FRIC_THR = 1'b0;
  localparam logic             REG_SLIP_THR = 1'b1;

  typedef struct packed {
    logic [15:0] friction_sample;
    logic [15:0] slip_spread_sample;
  } wvcd_in_t;

  typedef struct packed {
    logic        surface_changed;
    logic [12:0] change_confidence;
    logic [15:0] friction_window_var;
    logic [15:0] slip_window_var;
  } wvcd_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [WIN_AW-1:0] wr_idx;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_idx;
    logic              clr;
    logic              fin;
  } wvcd_lane_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIN   = 5'b01000,
    S_MERGE = 5'b10000
  } wvcd_state_t;

endpackage

// ===== rtl/wvcd_lane.sv =====
// One variance lane: a window history, a serial sum / sum-of-squares walk
// and the variance numerator N*sum(x^2) - (sum x)^2. Depends on wvcd_pkg.
module wvcd_lane
  import wvcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SMP_W-1:0]    fill_val,
  input  wvcd_lane_ctrl_t     ctrl,
  input  logic [SMP_W-1:0]    sample,
  output logic [NUM_W-1:0]    num
);

  logic [SMP_W-1:0] win_r [WIN_LEN];
  logic [SMP_W-1:0] x_r;
  logic             x_vld_r;
  logic [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]  q_r;
  logic [NUM_W-1:0] num_r;
  logic [2*SMP_W-1:0] sq;
  logic [2*SUM_W-1:0] ss;

  assign sq  = x_r * x_r;
  assign ss  = s_r * s_r;
  assign num = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= fill_val;
    end else if (ctrl.wr_en) begin
      win_r[ctrl.wr_idx] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) x_r <= win_r[ctrl.rd_idx];
    if (ctrl.clr) begin
      s_r <= '0;
      q_r <= '0;
    end else if (x_vld_r) begin
      s_r <= s_r + SUM_W'(x_r);
      q_r <= q_r + SQ_W'(sq);
    end
    if (ctrl.fin) num_r <= {q_r, {WIN_AW{1'b0}}} - NUM_W'(ss);
  end

endmodule

// ===== rtl/wvcd_merge.sv =====
// Merge stage: threshold compares, floored variances, confidence and the
// output register of the result channel. Depends on wvcd_pkg.
module wvcd_merge
  import wvcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [NUM_W-1:0] fric_num,
  input  logic [NUM_W-1:0] slip_num,
  input  logic [SMP_W-1:0] fric_thr,
  input  logic [SMP_W-1:0] slip_thr,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output wvcd_out_t        out_data
);

  logic             out_valid_r;
  wvcd_out_t        out_data_r;
  wvcd_out_t        res;
  logic [VAR_W-1:0] fvar;
  logic [VAR_W-1:0] svar;
  logic [VAR_W:0]   vsum;
  logic             changed;

  always_comb begin
    fvar    = fric_num[NUM_W-1:DEN_SHIFT];
    svar    = slip_num[NUM_W-1:DEN_SHIFT];
    vsum    = {1'b0, fvar} + {1'b0, svar};
    changed = (fric_num > (NUM_W'(fric_thr) << DEN_SHIFT)) ||
              (slip_num > (NUM_W'(slip_thr) << DEN_SHIFT));
    res.surface_changed = changed;
    if (!changed) begin
      res.change_confidence = '0;
    end else if (vsum > (VAR_W+1)'(CONF_MAX)) begin
      res.change_confidence = CONF_MAX;
    end else begin
      res.change_confidence = vsum[CONF_W-1:0];
    end
    res.friction_window_var = (fvar > VAR_W'(16'hFFFF)) ? 16'hFFFF : fvar[15:0];
    res.slip_window_var     = (svar > VAR_W'(16'hFFFF)) ? 16'hFFFF : svar[15:0];
  end

  assign free      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

endmodule

// ===== rtl/windowed_variance_change_detector.sv =====
// Top level of the windowed variance change detector: sequencer, config
// registers, two variance lanes and the merge stage. Depends on wvcd_pkg,
// wvcd_lane and wvcd_merge.
//
// Usage:
//   in_*  : valid/ready channel, one friction and one slip-spread sample per transfer.
//   out_* : valid/ready channel, one result per input transfer, in order.
//   cfg_* : APB-style port; threshold registers at byte 0 (friction) and 4 (slip).
//   Both lanes write the new samples at the shared slot, then walk their
//   16-entry windows one entry per cycle through a single squarer each.
//   The result passes from the walk through the drain, finish and merge states to the
//   output register; a new item is taken only once the merge step has loaded the result.
//   in_ready is high only while no item is in the lanes. The output register
//   holds a result while the receiver stalls; a new item is accepted meanwhile,
//   and its result waits in the merge step until the register frees.
//   Reset fills the friction window with 0.6, the slip window with 0, sets
//   the slot to 0 and the thresholds to 0.1 and 0.05. Reset is synchronous.
module windowed_variance_change_detector
  import wvcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wvcd_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wvcd_out_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  wvcd_state_t       state_r, state_nxt;
  logic [WIN_AW-1:0] slot_r, slot_nxt;
  logic [WIN_AW-1:0] cnt_r, cnt_nxt;
  logic [SMP_W-1:0]  fric_thr_r;
  logic [SMP_W-1:0]  slip_thr_r;
  wvcd_lane_ctrl_t   lane_ctrl;
  logic [NUM_W-1:0]  fric_num;
  logic [NUM_W-1:0]  slip_num;
  logic              merge_free;
  logic              merge_load;
  logic              in_xfer;
  logic              cfg_wr;

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign merge_load = (state_r == S_MERGE) && merge_free;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WALK;
          cnt_nxt   = '0;
          slot_nxt  = (slot_r == WIN_AW'(WIN_LEN - 1)) ? '0 : slot_r + 1'b1;
        end
      end
      S_WALK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == WIN_AW'(WIN_LEN - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_MERGE;
      S_MERGE: begin
        if (merge_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    lane_ctrl.wr_en  = in_xfer;
    lane_ctrl.wr_idx = slot_r;
    lane_ctrl.rd_en  = (state_r == S_WALK);
    lane_ctrl.rd_idx = cnt_r;
    lane_ctrl.clr    = in_xfer;
    lane_ctrl.fin    = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fric_thr_r <= FRIC_THR_RESET;
      slip_thr_r <= SLIP_THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRIC_THR: fric_thr_r <= cfg_pwdata[SMP_W-1:0];
        REG_SLIP_THR: slip_thr_r <= cfg_pwdata[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRIC_THR: cfg_prdata = {16'd0, fric_thr_r};
      REG_SLIP_THR: cfg_prdata = {16'd0, slip_thr_r};
      default:      cfg_prdata = '0;
    endcase
  end

  wvcd_lane u_fric_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .fill_val (FRIC_FILL),
    .ctrl     (lane_ctrl),
    .sample   (in_data.friction_sample),
    .num      (fric_num)
  );

  wvcd_lane u_slip_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .fill_val (SLIP_FILL),
    .ctrl     (lane_ctrl),
    .sample   (in_data.slip_spread_sample),
    .num      (slip_num)
  );

  wvcd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .fric_num  (fric_num),
    .slip_num  (slip_num),
    .fric_thr  (fric_thr_r),
    .slip_thr  (slip_thr_r),
    .free      (merge_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_WALK && !in_ready)
    else $error("input transfer did not start the window walk");

  a_conf_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.change_confidence <= CONF_MAX)
    else $error("confidence above 1.0");

  a_conf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.surface_changed |-> out_data.change_confidence == '0)
    else $error("confidence nonzero without a change flag");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    merge_load |=> out_valid && state_r == S_IDLE)
    else $error("merge load did not present a result");

endmodule

// ===== dv/windowed_variance_change_detector_test.sv =====
// Self-checking testbench for windowed_variance_change_detector: directed table, then
// random sample windows under several threshold settings, with random idling on both sides.
// Depends on wvcd_pkg and the RTL of the detector.
module windowed_variance_change_detector_test
  import wvcd_pkg::*;
();

  localparam int               WATCHDOG_LIMIT = 1000;
  localparam int               DIR_ROWS       = 24;
  localparam int               PHASES         = 6;
  localparam int               PHASE_ITEMS    = 280;
  localparam logic [63:0]      VAR_SCALE      = 64'(WIN_LEN) * 64'(WIN_LEN) * 64'd4096;
  localparam logic [CFG_AW-1:0] FRIC_ADDR     = {REG_FRIC_THR, 2'b00};
  localparam logic [CFG_AW-1:0] SLIP_ADDR     = {REG_SLIP_THR, 2'b00};

  typedef struct {
    wvcd_in_t  smp;
    bit        typed;
    wvcd_out_t rep;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  wvcd_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  wvcd_out_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic [15:0]       fric_hist [WIN_LEN];
  logic [15:0]       slip_hist [WIN_LEN];
  logic [WIN_AW-1:0] hist_slot;
  logic [15:0]       fric_limit;
  logic [15:0]       slip_limit;

  wvcd_out_t awaited_reports [$];
  stim_row_t directed_rows [DIR_ROWS];
  bit        calm;
  int        items_sent;
  int        reports_checked = 0;
  int        flagged_reports = 0;
  int        saturated_reports = 0;
  int        mismatch_count = 0;
  int        idle_cycles = 0;

  windowed_variance_change_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] spread_numerator(input bit slip_lane);
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] x;
    s = '0;
    q = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      x = slip_lane ? 64'(slip_hist[i]) : 64'(fric_hist[i]);
      s += x;
      q += x * x;
    end
    return 64'(WIN_LEN) * q - s * s;
  endfunction

  function automatic wvcd_out_t compute_window_report(input wvcd_in_t smp);
    wvcd_out_t   rep;
    logic [63:0] f_num;
    logic [63:0] s_num;
    logic [63:0] f_var;
    logic [63:0] s_var;
    logic [63:0] conf;
    logic        changed;
    fric_hist[hist_slot] = smp.friction_sample;
    slip_hist[hist_slot] = smp.slip_spread_sample;
    hist_slot = hist_slot + 1'b1;
    f_num = spread_numerator(1'b0);
    s_num = spread_numerator(1'b1);
    f_var = f_num / VAR_SCALE;
    s_var = s_num / VAR_SCALE;
    changed = (f_num > 64'(fric_limit) * VAR_SCALE) || (s_num > 64'(slip_limit) * VAR_SCALE);
    conf = '0;
    if (changed) begin
      conf = f_var + s_var;
      if (conf > 64'd4096) conf = 64'd4096;
    end
    rep.surface_changed     = changed;
    rep.change_confidence   = conf[12:0];
    rep.friction_window_var = (f_var > 64'hFFFF) ? 16'hFFFF : f_var[15:0];
    rep.slip_window_var     = (s_var > 64'hFFFF) ? 16'hFFFF : s_var[15:0];
    return rep;
  endfunction

  task automatic send_samples(input wvcd_in_t smp, input bit typed, input wvcd_out_t typed_rep);
    int        gap;
    wvcd_out_t rep;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (!in_ready);
    rep = compute_window_report(smp);
    awaited_reports.push_back(typed ? typed_rep : rep);
    items_sent++;
  endtask

  task automatic write_threshold(input logic [CFG_AW-1:0] addr, input logic [15:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {16'($urandom), val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == FRIC_ADDR) fric_limit = val;
    else slip_limit = val;
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall before each transfer.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    wvcd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: changed=%0d conf=%0d fvar=%0d svar=%0d",
                   out_data.surface_changed, out_data.change_confidence,
                   out_data.friction_window_var, out_data.slip_window_var);
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (want.surface_changed) flagged_reports++;
        if (want.friction_window_var == 16'hFFFF || want.slip_window_var == 16'hFFFF)
          saturated_reports++;
        if (out_data.surface_changed     !== want.surface_changed   ||
            out_data.change_confidence   !== want.change_confidence ||
            out_data.friction_window_var !== want.friction_window_var ||
            out_data.slip_window_var     !== want.slip_window_var) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on report %0d: expected changed=%0d conf=%0d fvar=%0d svar=%0d",
                     reports_checked, want.surface_changed, want.change_confidence,
                     want.friction_window_var, want.slip_window_var);
            $display("  got changed=%0d conf=%0d fvar=%0d svar=%0d",
                     out_data.surface_changed, out_data.change_confidence,
                     out_data.friction_window_var, out_data.slip_window_var);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, awaited_reports.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int        spreads [10];
    int        f_base;
    int        s_base;
    int        f_w;
    int        s_w;
    int        f_val;
    int        s_val;
    bit        noise;
    wvcd_in_t  smp;
    wvcd_out_t none;
    logic [15:0] phase_fric [PHASES];
    logic [15:0] phase_slip [PHASES];

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    none        = '0;
    items_sent = 0;

    for (int i = 0; i < WIN_LEN; i++) begin
      fric_hist[i] = 16'd2458;
      slip_hist[i] = 16'd0;
    end
    hist_slot  = '0;
    fric_limit = 16'd410;
    slip_limit = 16'd205;

    spreads = '{0, 1, 2, 64, 1024, 3000, 4500, 8192, 20000, 65535};
    phase_fric = '{16'd410, 16'd0, 16'hFFFF, 16'($urandom_range(0, 1200)), 16'd410, 16'hFFFF};
    phase_slip = '{16'd205, 16'd0, 16'hFFFF, 16'($urandom_range(0, 1200)), 16'd205, 16'd0};

    directed_rows[0] = '{smp: {16'd2458, 16'd0}, typed: 1'b1, rep: {1'b0, 13'd0, 16'd0, 16'd0}};
    directed_rows[1] = '{smp: {16'd2458, 16'd0}, typed: 1'b1, rep: {1'b0, 13'd0, 16'd0, 16'd0}};
    for (int i = 2; i < 18; i++)
      directed_rows[i] = '{smp: (i % 2 == 0) ? {16'd0, 16'hFFFF} : {16'hFFFF, 16'd0},
                           typed: 1'b0, rep: none};
    directed_rows[17] = '{smp: {16'hFFFF, 16'd0}, typed: 1'b1,
                          rep: {1'b1, 13'd4096, 16'hFFFF, 16'hFFFF}};
    directed_rows[18] = '{smp: {16'hFFFF, 16'hFFFF}, typed: 1'b0, rep: none};
    directed_rows[19] = '{smp: {16'd0, 16'd0}, typed: 1'b0, rep: none};
    directed_rows[20] = '{smp: {16'd4096, 16'd4096}, typed: 1'b0, rep: none};
    directed_rows[21] = '{smp: {16'd2458, 16'd205}, typed: 1'b0, rep: none};
    directed_rows[22] = '{smp: {16'd1, 16'd1}, typed: 1'b0, rep: none};
    directed_rows[23] = '{smp: {16'd32768, 16'd32768}, typed: 1'b0, rep: none};

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_samples(directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].rep);
    drain_reports();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_threshold(FRIC_ADDR, phase_fric[p]);
        write_threshold(SLIP_ADDR, phase_slip[p]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % WIN_LEN == 0) begin
          calm   = ($urandom_range(0, 3) == 0);
          noise  = ($urandom_range(0, 9) == 0);
          f_base = $urandom_range(0, 65535);
          s_base = $urandom_range(0, 65535);
          f_w    = spreads[$urandom_range(0, 9)];
          s_w    = spreads[$urandom_range(0, 9)];
          if ($urandom_range(0, 2) == 0) begin
            f_base = $urandom_range(0, 8192);
            s_base = $urandom_range(0, 4096);
          end
        end
        if (noise) begin
          f_val = $urandom_range(0, 65535);
          s_val = $urandom_range(0, 65535);
        end else begin
          f_val = f_base + $urandom_range(0, f_w);
          s_val = s_base + $urandom_range(0, s_w);
          if (f_val > 65535) f_val = 65535;
          if (s_val > 65535) s_val = 65535;
        end
        smp.friction_sample    = 16'(f_val);
        smp.slip_spread_sample = 16'(s_val);
        send_samples(smp, 1'b0, none);
      end
      drain_reports();
    end

    repeat (WIN_LEN + 8) @(posedge clk);

    $display("Sent %0d sample pairs over %0d threshold settings; checked %0d reports",
             items_sent, PHASES, reports_checked);
    $display("%0d reports flagged a surface change, %0d had a saturated variance",
             flagged_reports, saturated_reports);
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results missing", mismatch_count, awaited_reports.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
